[rtl/pdr_pkg.sv]
// ----------------------------------------------------------------------------
// pdr_pkg
// Shared types and constants of the packet dedup ring buffer.
// ----------------------------------------------------------------------------
package pdr_pkg;

  localparam int unsigned DEF_RING_SLOTS = 16;
  localparam int unsigned DEF_SLOT_BYTES = 256;

  localparam logic [15:0] WINDOW_RESET = 16'd5000;
  localparam logic [15:0] TICK_MAX     = 16'hFFFF;

  // Input function codes; the unused code is ignored.
  typedef enum logic [1:0] {
    FUNC_BYTE  = 2'd0,
    FUNC_TICK  = 2'd1,
    FUNC_DRAIN = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    VERDICT_QUEUED = 2'd0,
    VERDICT_DUP    = 2'd1,
    VERDICT_FULL   = 2'd2
  } verdict_e;

  typedef enum logic {
    KIND_VERDICT = 1'b0,
    KIND_DRAIN   = 1'b1
  } kind_e;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic       result_kind;
    logic [1:0] verdict;
    logic [7:0] out_byte;
    logic       out_last;
    logic       out_valid;
  } out_item_t;

endpackage

[rtl/pdr_stream_if.sv]
// ----------------------------------------------------------------------------
// pdr stream interfaces
// Valid/ready channels for input items, result items and the config write.
// ----------------------------------------------------------------------------
interface pdr_in_if;
  logic             valid;
  logic             ready;
  pdr_pkg::in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface pdr_out_if;
  logic               valid;
  logic               ready;
  pdr_pkg::out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface pdr_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/packet_dedup_ring_buffer.sv]
// ----------------------------------------------------------------------------
// packet_dedup_ring_buffer
// Byte-wise packet staging with duplicate suppression and a slot FIFO.
// ----------------------------------------------------------------------------
// The block takes one input item per clock when not stalled (packet byte,
// millisecond tick or drain request) and returns each result through a load
// stage and an output register, so a waiting result does not
// hold off the input until both stages are full. Packet bytes go into the
// head slot of the ring RAM and are compared against a last-packet RAM; the
// last-packet word and the length of the tail slot are read one position
// ahead, so every decision is made in the cycle of the transfer and the next
// item may follow at once. Drained bytes come out of the ring RAM read port.
// The stores need no clearing pass after reset: every entry is written before
// it is read. At most RING_SLOTS - 1 packets are queued.
// ----------------------------------------------------------------------------
module packet_dedup_ring_buffer #(
  parameter int unsigned RING_SLOTS = pdr_pkg::DEF_RING_SLOTS,
  parameter int unsigned SLOT_BYTES = pdr_pkg::DEF_SLOT_BYTES
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pdr_cfg_if.sink   cfg_i,
  pdr_in_if.sink    in_i,
  pdr_out_if.source out_o
);

  localparam int unsigned SW = $clog2(RING_SLOTS);
  localparam int unsigned PW = $clog2(SLOT_BYTES);
  localparam int unsigned LW = $clog2(SLOT_BYTES + 1);
  localparam int unsigned RD = RING_SLOTS * SLOT_BYTES;
  localparam int unsigned AW = $clog2(RD);

  function automatic logic [SW-1:0] next_slot(input logic [SW-1:0] s);
    logic [SW-1:0] n;
    if (s == SW'(RING_SLOTS - 1)) begin
      n = '0;
    end else begin
      n = s + SW'(1);
    end
    return n;
  endfunction

  // Architectural state
  logic [SW-1:0] head_q, head_d;
  logic [SW-1:0] tail_q, tail_d;
  logic [PW-1:0] dpos_q, dpos_d;
  logic [LW-1:0] prev_len_q, prev_len_d;
  logic [LW-1:0] wpos_q, wpos_d;
  logic          mism_q, mism_d;
  logic [15:0]   ticks_q, ticks_d;
  logic [15:0]   window_q;

  // Read-ahead bypass for the last-packet and slot-length RAMs
  logic          prev_fwd_q, prev_fwd_d;
  logic [7:0]    prev_fwd_byte_q;
  logic          slen_fwd_q, slen_fwd_d;
  logic [LW-1:0] slen_fwd_len_q;

  // RAM ports
  logic          ring_we, ring_re;
  logic [AW-1:0] ring_waddr, ring_raddr;
  logic [7:0]    ring_rdata;
  logic          prev_we;
  logic [PW-1:0] prev_waddr, prev_raddr;
  logic [7:0]    prev_rdata, prev_data;
  logic          slen_we;
  logic [LW-1:0] slen_rdata, slen_cur;

  // Pipeline
  logic               s1_v_q;
  logic               s1_kind_q, s1_last_q, s1_ovalid_q, s1_rd_q;
  pdr_pkg::verdict_e  s1_verdict_q;
  logic               s1_load;
  logic               s1_kind_d, s1_last_d, s1_ovalid_d, s1_rd_d;
  pdr_pkg::verdict_e  s1_verdict_d;
  logic               s1_adv;
  logic               out_v_q;
  pdr_pkg::out_item_t out_item_q;

  logic          in_ready;
  logic          in_fire;
  logic          in_range, byte_miss, mism_new, is_dup;
  logic [LW-1:0] wpos_inc;
  logic          fin;

  assign s1_adv   = s1_v_q && (!out_v_q || out_o.ready);
  assign in_ready = !s1_v_q || s1_adv;
  assign in_fire  = in_i.valid && in_ready;

  assign prev_data = prev_fwd_q ? prev_fwd_byte_q : prev_rdata;
  assign slen_cur  = slen_fwd_q ? slen_fwd_len_q : slen_rdata;

  assign in_range   = wpos_q < LW'(SLOT_BYTES);
  assign prev_waddr = wpos_q[PW-1:0];
  assign ring_waddr = AW'(head_q) * AW'(SLOT_BYTES) + AW'(wpos_q[PW-1:0]);
  assign ring_raddr = AW'(tail_q) * AW'(SLOT_BYTES) + AW'(dpos_q);
  assign wpos_inc   = in_range ? wpos_q + LW'(1) : wpos_q;
  assign byte_miss  = in_range && ((wpos_q >= prev_len_q) || (prev_data != in_i.item.data_byte));
  assign mism_new   = mism_q || byte_miss;
  assign is_dup     = !mism_new && (wpos_inc == prev_len_q);
  assign fin        = (LW'(dpos_q) + LW'(1)) >= slen_cur;

  always_comb begin
    head_d       = head_q;
    tail_d       = tail_q;
    dpos_d       = dpos_q;
    prev_len_d   = prev_len_q;
    wpos_d       = wpos_q;
    mism_d       = mism_q;
    ticks_d      = ticks_q;
    ring_we      = 1'b0;
    ring_re      = 1'b0;
    prev_we      = 1'b0;
    slen_we      = 1'b0;
    s1_load      = 1'b0;
    s1_kind_d    = pdr_pkg::KIND_VERDICT;
    s1_verdict_d = pdr_pkg::VERDICT_QUEUED;
    s1_last_d    = 1'b0;
    s1_ovalid_d  = 1'b1;
    s1_rd_d      = 1'b0;
    if (in_fire) begin
      unique case (in_i.item.func)
        pdr_pkg::FUNC_BYTE: begin
          prev_we = in_range;
          ring_we = in_range;
          if (in_i.item.last_byte) begin
            s1_load    = 1'b1;
            wpos_d     = '0;
            mism_d     = 1'b0;
            prev_len_d = wpos_inc;
            priority if (is_dup && (ticks_q < window_q)) begin
              s1_verdict_d = pdr_pkg::VERDICT_DUP;
            end else if (next_slot(head_q) == tail_q) begin
              s1_verdict_d = pdr_pkg::VERDICT_FULL;
            end else begin
              s1_verdict_d = pdr_pkg::VERDICT_QUEUED;
              slen_we      = 1'b1;
              head_d       = next_slot(head_q);
              ticks_d      = '0;
            end
          end else begin
            wpos_d = wpos_inc;
            mism_d = mism_new;
          end
        end
        pdr_pkg::FUNC_TICK: begin
          if (ticks_q != pdr_pkg::TICK_MAX) begin
            ticks_d = ticks_q + 16'd1;
          end
        end
        pdr_pkg::FUNC_DRAIN: begin
          s1_load   = 1'b1;
          s1_kind_d = pdr_pkg::KIND_DRAIN;
          if (head_q == tail_q) begin
            s1_ovalid_d = 1'b0;
          end else begin
            ring_re   = 1'b1;
            s1_rd_d   = 1'b1;
            s1_last_d = fin;
            if (fin) begin
              dpos_d = '0;
              tail_d = next_slot(tail_q);
            end else begin
              dpos_d = dpos_q + PW'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Read one position ahead; bypass when that entry is written in the same cycle
  assign prev_raddr = (wpos_d < LW'(SLOT_BYTES)) ? wpos_d[PW-1:0] : '0;
  assign prev_fwd_d = prev_we && (prev_raddr == prev_waddr);
  assign slen_fwd_d = slen_we && (tail_d == head_q);

  pdr_ram #(.WIDTH(8), .DEPTH(RD)) u_ring_ram (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (ring_waddr),
    .wdata_i (in_i.item.data_byte),
    .re_i    (ring_re),
    .raddr_i (ring_raddr),
    .rdata_o (ring_rdata)
  );

  pdr_ram #(.WIDTH(8), .DEPTH(SLOT_BYTES)) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (prev_we),
    .waddr_i (prev_waddr),
    .wdata_i (in_i.item.data_byte),
    .re_i    (1'b1),
    .raddr_i (prev_raddr),
    .rdata_o (prev_rdata)
  );

  pdr_ram #(.WIDTH(LW), .DEPTH(RING_SLOTS)) u_slen_ram (
    .clk_i   (clk_i),
    .we_i    (slen_we),
    .waddr_i (head_q),
    .wdata_i (wpos_inc),
    .re_i    (1'b1),
    .raddr_i (tail_d),
    .rdata_o (slen_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q     <= '0;
      tail_q     <= '0;
      dpos_q     <= '0;
      prev_len_q <= '0;
      wpos_q     <= '0;
      mism_q     <= 1'b0;
      ticks_q    <= '0;
      window_q   <= pdr_pkg::WINDOW_RESET;
      prev_fwd_q <= 1'b0;
      slen_fwd_q <= 1'b0;
      s1_v_q     <= 1'b0;
      out_v_q    <= 1'b0;
    end else begin
      head_q     <= head_d;
      tail_q     <= tail_d;
      dpos_q     <= dpos_d;
      prev_len_q <= prev_len_d;
      wpos_q     <= wpos_d;
      mism_q     <= mism_d;
      ticks_q    <= ticks_d;
      prev_fwd_q <= prev_fwd_d;
      slen_fwd_q <= slen_fwd_d;
      if (cfg_i.valid) begin
        window_q <= cfg_i.data;
      end
      if (s1_load) begin
        s1_v_q <= 1'b1;
      end else if (s1_adv) begin
        s1_v_q <= 1'b0;
      end
      if (s1_adv) begin
        out_v_q <= 1'b1;
      end else if (out_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (prev_fwd_d) begin
      prev_fwd_byte_q <= in_i.item.data_byte;
    end
    if (slen_fwd_d) begin
      slen_fwd_len_q <= wpos_inc;
    end
    if (s1_load) begin
      s1_kind_q    <= s1_kind_d;
      s1_verdict_q <= s1_verdict_d;
      s1_last_q    <= s1_last_d;
      s1_ovalid_q  <= s1_ovalid_d;
      s1_rd_q      <= s1_rd_d;
    end
    if (s1_adv) begin
      out_item_q.result_kind <= s1_kind_q;
      out_item_q.verdict     <= s1_verdict_q;
      out_item_q.out_byte    <= s1_rd_q ? ring_rdata : 8'd0;
      out_item_q.out_last    <= s1_last_q;
      out_item_q.out_valid   <= s1_ovalid_q;
    end
  end

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = in_ready;
  assign out_o.valid = out_v_q;
  assign out_o.item  = out_item_q;

  // The drain read port must never touch the staging slot
  a_drain_not_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ring_re |-> (tail_q != head_q))
    else $error("drain read hits the staging slot");

  // A held drain byte in the load stage must not be overwritten by a new read
  a_hold_ring_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q && !s1_adv) |-> !ring_re)
    else $error("ring read while a drained byte is held");

  a_wpos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wpos_q <= LW'(SLOT_BYTES))
    else $error("write position beyond slot size");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready |-> (s1_v_q && out_v_q && !out_o.ready))
    else $error("input stalled with room in the pipeline");

  a_queue_clears_ticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slen_we |=> (ticks_q == 16'd0) && (head_q != $past(head_q)))
    else $error("queued packet did not advance head or clear the tick count");

endmodule

[rtl/pdr_ram.sv]
// ----------------------------------------------------------------------------
// pdr_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// A read of the address being written returns the old contents.
// ----------------------------------------------------------------------------
module pdr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives packet bytes, millisecond ticks and drain requests into the packet
// dedup ring buffer under random sender bursts and receiver stalls, predicts
// every verdict and drained byte, and checks each result field by field.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned RING_SLOTS = pdr_pkg::DEF_RING_SLOTS;
  localparam int unsigned SLOT_BYTES = pdr_pkg::DEF_SLOT_BYTES;
  localparam int unsigned SLOT_W     = $clog2(RING_SLOTS);
  localparam int unsigned POS_W      = $clog2(SLOT_BYTES);
  localparam logic [1:0]  FUNC_UNUSED = 2'd3;
  localparam int          STALL_LIMIT = 3000;
  localparam int          PRESSURE_HOLD = 150;
  localparam int          DRAIN_SETTLE = 8;

  typedef logic [7:0] byte_q_t[$];

  logic clk_i;
  logic rst_ni;

  pdr_cfg_if cfg_if ();
  pdr_in_if  in_if ();
  pdr_out_if out_if ();

  packet_dedup_ring_buffer i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Mirror of the block state.
  logic [7:0]        ring_mem [RING_SLOTS][SLOT_BYTES];
  logic [POS_W:0]    slot_len [RING_SLOTS];
  logic [SLOT_W-1:0] head_slot;
  logic [SLOT_W-1:0] tail_slot;
  logic [POS_W-1:0]  drain_pos;
  logic [7:0]        last_pkt [SLOT_BYTES];
  logic [POS_W:0]    last_len;
  logic [POS_W:0]    wr_pos;
  logic              diff_seen;
  logic [15:0]       tick_count;
  logic [15:0]       dup_window;

  pdr_pkg::in_item_t  stream_items_q[$];
  pdr_pkg::out_item_t ring_results_q[$];
  byte_q_t            last_sent;

  int n_gen;
  int n_in;
  int n_queued;
  int n_dup;
  int n_full;
  int n_drained;
  int n_empty_drain;
  int n_bad;
  int burst_left;
  int gap_left;
  int recv_cyc;
  int hold_left;
  int idle_cycles;
  bit hold_req;
  bit hold_done;
  pdr_pkg::out_item_t got;
  pdr_pkg::out_item_t want;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic apply_to_dedup_ring(input pdr_pkg::in_item_t it);
    logic [POS_W:0]     pkt_len;
    logic               same;
    logic               fin;
    logic [SLOT_W-1:0]  nxt;
    pdr_pkg::verdict_e  v;
    pdr_pkg::out_item_t res;
    res = '0;
    case (it.func)
      pdr_pkg::FUNC_BYTE: begin
        if (wr_pos < SLOT_BYTES) begin
          if (wr_pos >= last_len || last_pkt[wr_pos[POS_W-1:0]] != it.data_byte)
            diff_seen = 1'b1;
          last_pkt[wr_pos[POS_W-1:0]] = it.data_byte;
          ring_mem[head_slot][wr_pos[POS_W-1:0]] = it.data_byte;
          wr_pos = wr_pos + 1'b1;
        end
        if (it.last_byte) begin
          pkt_len   = wr_pos;
          same      = !diff_seen && (pkt_len == last_len);
          wr_pos    = '0;
          diff_seen = 1'b0;
          last_len  = pkt_len;
          nxt       = head_slot + 1'b1;
          if (same && tick_count < dup_window) begin
            v = pdr_pkg::VERDICT_DUP;
            n_dup++;
          end else if (nxt == tail_slot) begin
            v = pdr_pkg::VERDICT_FULL;
            n_full++;
          end else begin
            slot_len[head_slot] = pkt_len;
            head_slot  = nxt;
            tick_count = '0;
            v = pdr_pkg::VERDICT_QUEUED;
            n_queued++;
          end
          res.result_kind = pdr_pkg::KIND_VERDICT;
          res.verdict     = v;
          res.out_valid   = 1'b1;
          ring_results_q.push_back(res);
        end
      end
      pdr_pkg::FUNC_TICK: begin
        if (tick_count != pdr_pkg::TICK_MAX) tick_count = tick_count + 1'b1;
      end
      pdr_pkg::FUNC_DRAIN: begin
        res.result_kind = pdr_pkg::KIND_DRAIN;
        res.verdict     = pdr_pkg::VERDICT_QUEUED;
        if (head_slot == tail_slot) begin
          n_empty_drain++;
        end else begin
          fin = ({1'b0, drain_pos} + 1'b1) >= slot_len[tail_slot];
          res.out_byte  = ring_mem[tail_slot][drain_pos];
          res.out_last  = fin;
          res.out_valid = 1'b1;
          n_drained++;
          if (fin) begin
            drain_pos = '0;
            tail_slot = tail_slot + 1'b1;
          end else begin
            drain_pos = drain_pos + 1'b1;
          end
        end
        ring_results_q.push_back(res);
      end
      default: ;
    endcase
  endtask

  task automatic push_item(input logic [1:0] f, input logic [7:0] d, input logic l);
    pdr_pkg::in_item_t it;
    it.func      = f;
    it.data_byte = d;
    it.last_byte = l;
    stream_items_q.push_back(it);
    if (f != FUNC_UNUSED) n_gen++;
  endtask

  task automatic push_noise();
    int r;
    r = $urandom_range(0, 2);
    push_item(r == 0 ? pdr_pkg::FUNC_TICK : (r == 1 ? pdr_pkg::FUNC_DRAIN : FUNC_UNUSED),
              8'($urandom), 1'($urandom));
  endtask

  task automatic send_packet(input byte_q_t pkt, input int noise_pct);
    for (int i = 0; i < pkt.size(); i++) begin
      if ($urandom_range(0, 99) < noise_pct) push_noise();
      push_item(pdr_pkg::FUNC_BYTE, pkt[i], i == pkt.size() - 1);
    end
    last_sent = pkt;
  endtask

  task automatic make_packet(output byte_q_t pkt);
    int r;
    int n;
    int idx;
    r = $urandom_range(0, 99);
    pkt = {};
    if (last_sent.size() == 0 || r < 30) begin
      n = $urandom_range(0, 99);
      if (n < 3) n = $urandom_range(200, SLOT_BYTES);
      else if (n < 5) n = $urandom_range(SLOT_BYTES + 1, SLOT_BYTES + 44);
      else n = $urandom_range(1, 12);
      repeat (n) pkt.push_back(8'($urandom));
    end else if (r < 65) begin
      pkt = last_sent;
    end else if (r < 80) begin
      // flip one byte of the last packet
      pkt = last_sent;
      idx = $urandom_range(0, pkt.size() - 1);
      pkt[idx] = pkt[idx] ^ 8'($urandom_range(1, 255));
    end else if (r < 90 && last_sent.size() > 1) begin
      pkt = last_sent[0:$urandom_range(0, last_sent.size() - 2)];
    end else begin
      pkt = last_sent;
      repeat ($urandom_range(1, 3)) pkt.push_back(8'($urandom));
    end
  endtask

  task automatic settle();
    do @(posedge clk_i);
    while (stream_items_q.size() != 0 || in_if.valid || ring_results_q.size() != 0);
    // let trailing ticks and bytes clear the pipeline
    repeat (DRAIN_SETTLE) @(posedge clk_i);
  endtask

  task automatic write_dup_window(input logic [15:0] w);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= w;
    do @(posedge clk_i);
    while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    dup_window = w;
  endtask

  task automatic run_random(input int n_target, input int tick_hi, input int drain_hi,
                            input int noise_pct);
    int start;
    int r;
    byte_q_t pkt;
    start = n_gen;
    while (n_gen - start < n_target) begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        make_packet(pkt);
        send_packet(pkt, noise_pct);
      end else if (r < 75) begin
        repeat ($urandom_range(0, tick_hi))
          push_item(pdr_pkg::FUNC_TICK, 8'($urandom), 1'($urandom));
      end else begin
        repeat ($urandom_range(1, drain_hi))
          push_item(pdr_pkg::FUNC_DRAIN, 8'($urandom), 1'($urandom));
      end
    end
    settle();
  endtask

  // Request exactly as many drains as bytes are still queued.
  task automatic empty_ring();
    int n;
    logic [SLOT_W-1:0] s;
    n = 0;
    if (head_slot != tail_slot) begin
      n = slot_len[tail_slot] - drain_pos;
      s = tail_slot + 1'b1;
      while (s != head_slot) begin
        n = n + slot_len[s];
        s = s + 1'b1;
      end
    end
    repeat (n) push_item(pdr_pkg::FUNC_DRAIN, 8'($urandom), 1'($urandom));
    settle();
  endtask

  // Sender: bursts of random length with random gaps.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      burst_left = 4;
      gap_left   = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        apply_to_dedup_ring(in_if.item);
        void'(stream_items_q.pop_front());
        n_in++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_if.valid <= 1'b0;
        end else if (stream_items_q.size() != 0) begin
          in_if.valid <= 1'b1;
          in_if.item  <= stream_items_q[0];
          burst_left--;
          if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                      : $urandom_range(1, 12);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: rotating stall pattern, rare long holds, one forced hold-off.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      recv_cyc  = 0;
      hold_left = 0;
      hold_done = 1'b0;
    end else begin
      recv_cyc++;
      if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = PRESSURE_HOLD;
        out_if.ready <= 1'b0;
      end else if ($urandom_range(0, 499) == 0) begin
        hold_left = $urandom_range(40, 120);
        out_if.ready <= 1'b0;
      end else begin
        case (recv_cyc[8:7])
          2'd0:    out_if.ready <= 1'b1;
          2'd1:    out_if.ready <= 1'($urandom_range(0, 1));
          2'd2:    out_if.ready <= ($urandom_range(0, 3) == 0);
          default: out_if.ready <= recv_cyc[1];
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = out_if.item;
      if (ring_results_q.size() == 0) begin
        n_bad++;
        if (n_bad <= 10)
          $display("unexpected result: kind %0d verdict %0d byte %02h last %0d valid %0d",
                   got.result_kind, got.verdict, got.out_byte, got.out_last, got.out_valid);
      end else begin
        want = ring_results_q.pop_front();
        if (got.result_kind !== want.result_kind || got.verdict !== want.verdict ||
            got.out_byte !== want.out_byte || got.out_last !== want.out_last ||
            got.out_valid !== want.out_valid) begin
          n_bad++;
          if (n_bad <= 10)
            $display({"mismatch (expected/actual): kind %0d/%0d verdict %0d/%0d ",
                      "byte %02h/%02h last %0d/%0d valid %0d/%0d"},
                     want.result_kind, got.result_kind, want.verdict, got.verdict,
                     want.out_byte, got.out_byte, want.out_last, got.out_last,
                     want.out_valid, got.out_valid);
        end
      end
    end
  end

  // Watchdog: cycles without any transfer on any channel.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles = 0;
    end else begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
        $display("[packet_dedup_ring_buffer] ERROR");
        $finish;
      end
    end
  end

  initial begin
    byte_q_t pkt;
    logic [15:0] w_small;
    logic [15:0] w_mid;
    rst_ni        = 1'b0;
    in_if.valid   = 1'b0;
    in_if.item    = '0;
    out_if.ready  = 1'b0;
    cfg_if.valid  = 1'b0;
    cfg_if.data   = '0;
    hold_req      = 1'b0;
    head_slot     = '0;
    tail_slot     = '0;
    drain_pos     = '0;
    last_len      = '0;
    wr_pos        = '0;
    diff_seen     = 1'b0;
    tick_count    = '0;
    dup_window    = pdr_pkg::WINDOW_RESET;
    n_gen = 0; n_in = 0; n_queued = 0; n_dup = 0; n_full = 0;
    n_drained = 0; n_empty_drain = 0; n_bad = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty drain, ignored code, repeats, prefix, drain mid-packet.
    push_item(pdr_pkg::FUNC_DRAIN, 8'hFF, 1'b1);
    push_item(FUNC_UNUSED, 8'hFF, 1'b1);
    push_item(pdr_pkg::FUNC_TICK, 8'h00, 1'b1);
    pkt = {8'h00, 8'hFF};
    send_packet(pkt, 0);
    send_packet(pkt, 0);
    pkt = {8'h00};
    send_packet(pkt, 0);
    pkt = {8'h00, 8'hFF, 8'h80};
    send_packet(pkt, 0);
    push_item(pdr_pkg::FUNC_BYTE, 8'h7F, 1'b0);
    push_item(pdr_pkg::FUNC_DRAIN, 8'h00, 1'b0);
    push_item(pdr_pkg::FUNC_DRAIN, 8'h00, 1'b0);
    push_item(pdr_pkg::FUNC_BYTE, 8'h01, 1'b1);
    push_item(pdr_pkg::FUNC_TICK, 8'hAA, 1'b0);
    settle();

    // Hold the receiver off while packets fill the ring and drains pile up.
    hold_req = 1'b1;
    for (int i = 0; i < 16; i++) begin
      pkt = {8'(8'h10 + i)};
      send_packet(pkt, 0);
    end
    repeat (30) push_item(pdr_pkg::FUNC_DRAIN, 8'($urandom), 1'($urandom));
    settle();

    write_dup_window(16'd1);
    run_random(400, 2, 40, 10);

    write_dup_window(16'd0);
    run_random(300, 3, 4, 5);

    // Widest window: a repeat after a few hundred ticks is still suppressed.
    write_dup_window(16'hFFFF);
    empty_ring();
    pkt = {8'h3C};
    send_packet(pkt, 0);
    pkt = {8'h3C, 8'hC3, 8'h00, 8'hFF};
    send_packet(pkt, 0);
    repeat (300) push_item(pdr_pkg::FUNC_TICK, 8'($urandom), 1'($urandom));
    send_packet(pkt, 0);
    repeat (2) push_item(pdr_pkg::FUNC_TICK, 8'($urandom), 1'($urandom));
    send_packet(pkt, 0);
    settle();
    run_random(300, 50, 30, 10);

    w_small = 16'($urandom_range(2, 20));
    write_dup_window(w_small);
    run_random(400, 2 * w_small, 12, 10);

    w_mid = 16'($urandom_range(20, 60));
    write_dup_window(w_mid);
    run_random(200, w_mid, 20, 15);

    $display("covered %0d input transfers: %0d packets queued, %0d suppressed, %0d dropped full",
             n_in, n_queued, n_dup, n_full);
    $display("drained %0d bytes, %0d drains on an empty ring; windows 5000 1 0 65535 %0d %0d",
             n_drained, n_empty_drain, w_small, w_mid);
    if (n_bad == 0 && ring_results_q.size() == 0) begin
      $display("[packet_dedup_ring_buffer] OK");
    end else begin
      $display("%0d mismatches, %0d results missing", n_bad, ring_results_q.size());
      $display("[packet_dedup_ring_buffer] ERROR");
    end
    $finish;
  end

endmodule

[files.f]
rtl/pdr_pkg.sv
rtl/pdr_stream_if.sv
rtl/pdr_ram.sv
rtl/packet_dedup_ring_buffer.sv
tb/testbench.sv
